// File: rtl/first_fit_segment_allocator_assert.svh
// Assertion helpers for the checker file.
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define FFSA_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define FFSA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define FFSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ffsa_pkg.sv
package ffsa_pkg;

  localparam int MEM_SIZE       = 1024;
  localparam int MAX_SEG        = 16;
  localparam int MAX_PROCESS_ID = 255;

  localparam int BASE_W = 10;
  localparam int LEN_W  = 11;
  localparam int PID_W  = 8;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;
  localparam int IDX_W  = $clog2(MAX_SEG);
  localparam int CNT_W  = $clog2(MAX_SEG + 1);

  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFIT   = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOOWNER = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [BASE_W-1:0] base;
    logic [LEN_W-1:0]  len;
    logic [PID_W-1:0]  owner;
    logic              used;
  } entry_t;

  typedef enum logic [1:0] {
    TBL_NOP,
    TBL_WRITE,
    TBL_SPLIT,
    TBL_MERGE
  } tbl_op_e;

  typedef struct packed {
    tbl_op_e          op;
    logic [IDX_W-1:0] idx;
    entry_t           ent;
    entry_t           ent2;
  } tbl_cmd_t;

endpackage

// File: rtl/ffsa_if.sv
interface ffsa_req_if import ffsa_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [LEN_W-1:0]  request_size;
  logic [PID_W-1:0]  process_id;

  modport source (output valid, command, request_size, process_id, input ready);
  modport sink   (input valid, command, request_size, process_id, output ready);
endinterface

interface ffsa_rsp_if import ffsa_pkg::*;;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [BASE_W-1:0] block_start;
  logic [LEN_W-1:0]  free_total;
  logic [LEN_W-1:0]  allocated_total;

  modport source (output valid, status, block_start, free_total, allocated_total,
                  input ready);
  modport sink   (input valid, status, block_start, free_total, allocated_total,
                  output ready);
endinterface

// File: rtl/ffsa_table.sv
module ffsa_table import ffsa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tbl_cmd_t         cmd_i,
  input  logic [IDX_W-1:0] rd_idx_i,
  output entry_t           rd_entry_o,
  output logic [CNT_W-1:0] count_o
);

  entry_t           tbl_q [MAX_SEG];
  entry_t           tbl_d [MAX_SEG];
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    tbl_d = tbl_q;
    cnt_d = cnt_q;
    unique case (cmd_i.op)
      TBL_NOP: ;
      TBL_WRITE: begin
        tbl_d[cmd_i.idx] = cmd_i.ent;
      end
      TBL_SPLIT: begin
        // open a slot behind idx, entries above move up by one
        for (int k = 1; k < MAX_SEG; k++) begin
          if (k > int'(cmd_i.idx) + 1) begin
            tbl_d[k] = tbl_q[k-1];
          end
        end
        tbl_d[cmd_i.idx]              = cmd_i.ent;
        tbl_d[cmd_i.idx + IDX_W'(1)]  = cmd_i.ent2;
        cnt_d = cnt_q + CNT_W'(1);
      end
      TBL_MERGE: begin
        // drop entry idx, entries above move down by one
        for (int k = 0; k < MAX_SEG - 1; k++) begin
          if (k >= int'(cmd_i.idx)) begin
            tbl_d[k] = tbl_q[k+1];
          end
        end
        tbl_d[MAX_SEG-1]             = '0;
        tbl_d[cmd_i.idx - IDX_W'(1)] = cmd_i.ent;
        cnt_d = cnt_q - CNT_W'(1);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_SEG; k++) begin
        tbl_q[k] <= '0;
      end
      tbl_q[0].len <= LEN_W'(MEM_SIZE);
      cnt_q        <= CNT_W'(1);
    end else begin
      tbl_q <= tbl_d;
      cnt_q <= cnt_d;
    end
  end

  assign rd_entry_o = tbl_q[rd_idx_i];
  assign count_o    = cnt_q;

endmodule

// File: rtl/ffsa_ctrl.sv
module ffsa_ctrl import ffsa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  logic [CMD_W-1:0]  req_command_i,
  input  logic [LEN_W-1:0]  req_size_i,
  input  logic [PID_W-1:0]  req_pid_i,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output logic [STAT_W-1:0] rsp_status_o,
  output logic [BASE_W-1:0] rsp_start_o,
  output logic [LEN_W-1:0]  used_total_o,
  output tbl_cmd_t          tbl_cmd_o,
  output logic [IDX_W-1:0]  tbl_idx_o,
  input  entry_t            tbl_entry_i,
  input  logic [CNT_W-1:0]  tbl_count_i
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_MERGE = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [LEN_W-1:0]  used_q, used_d;
  logic [CMD_W-1:0]  cmd_q, cmd_d;
  logic [LEN_W-1:0]  size_q, size_d;
  logic [PID_W-1:0]  pid_q, pid_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  entry_t            hold_q, hold_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic [BASE_W-1:0] start_q, start_d;

  logic is_alloc, hit, last;

  assign is_alloc = (cmd_q == CMD_ALLOC);
  assign hit  = is_alloc ? (!tbl_entry_i.used && (tbl_entry_i.len >= size_q))
                         : (tbl_entry_i.used && (tbl_entry_i.owner == pid_q));
  assign last = ((CNT_W'(idx_q) + CNT_W'(1)) == tbl_count_i);

  always_comb begin
    state_d  = state_q;
    used_d   = used_q;
    cmd_d    = cmd_q;
    size_d   = size_q;
    pid_d    = pid_q;
    idx_d    = idx_q;
    hold_d   = hold_q;
    status_d = status_q;
    start_d  = start_q;
    tbl_cmd_o.op   = TBL_NOP;
    tbl_cmd_o.idx  = idx_q;
    tbl_cmd_o.ent  = '0;
    tbl_cmd_o.ent2 = '0;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_d    = req_command_i;
          size_d   = req_size_i;
          pid_d    = req_pid_i;
          idx_d    = '0;
          status_d = ST_OK;
          start_d  = '0;
          if (req_command_i == CMD_ALLOC && req_size_i == '0) begin
            status_d = ST_NOFIT;
            state_d  = S_OUT;
          end else if (req_command_i == CMD_ALLOC || req_command_i == CMD_FREE) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_SCAN: begin
        if (hit && is_alloc) begin
          state_d = S_OUT;
          if (tbl_entry_i.len == size_q) begin
            tbl_cmd_o.op        = TBL_WRITE;
            tbl_cmd_o.ent       = tbl_entry_i;
            tbl_cmd_o.ent.owner = pid_q;
            tbl_cmd_o.ent.used  = 1'b1;
            used_d  = used_q + size_q;
            start_d = tbl_entry_i.base;
          end else if (tbl_count_i == CNT_W'(MAX_SEG)) begin
            status_d = ST_FULL;
          end else begin
            tbl_cmd_o.op        = TBL_SPLIT;
            tbl_cmd_o.ent.base  = tbl_entry_i.base;
            tbl_cmd_o.ent.len   = size_q;
            tbl_cmd_o.ent.owner = pid_q;
            tbl_cmd_o.ent.used  = 1'b1;
            tbl_cmd_o.ent2.base = tbl_entry_i.base + size_q[BASE_W-1:0];
            tbl_cmd_o.ent2.len  = tbl_entry_i.len - size_q;
            used_d  = used_q + size_q;
            start_d = tbl_entry_i.base;
          end
        end else if (hit) begin
          tbl_cmd_o.op       = TBL_WRITE;
          tbl_cmd_o.ent.base = tbl_entry_i.base;
          tbl_cmd_o.ent.len  = tbl_entry_i.len;
          used_d = used_q - tbl_entry_i.len;
          if (last) begin
            state_d = S_OUT;
          end else begin
            hold_d       = '0;
            hold_d.base  = tbl_entry_i.base;
            hold_d.len   = tbl_entry_i.len;
            idx_d        = idx_q + IDX_W'(1);
            state_d      = S_MERGE;
          end
        end else if (last) begin
          status_d = is_alloc ? ST_NOFIT : ST_NOOWNER;
          state_d  = S_OUT;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      S_MERGE: begin
        if (!tbl_entry_i.used) begin
          tbl_cmd_o.op       = TBL_MERGE;
          tbl_cmd_o.ent.base = hold_q.base;
          tbl_cmd_o.ent.len  = hold_q.len + tbl_entry_i.len;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (rsp_ready_i) begin
          state_d = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    size_q   <= size_d;
    pid_q    <= pid_d;
    idx_q    <= idx_d;
    hold_q   <= hold_d;
    status_q <= status_d;
    start_q  <= start_d;
  end

  assign req_ready_o  = (state_q == S_IDLE);
  assign rsp_valid_o  = (state_q == S_OUT);
  assign rsp_status_o = status_q;
  assign rsp_start_o  = start_q;
  assign used_total_o = used_q;
  assign tbl_idx_o    = idx_q;

endmodule

// File: rtl/first_fit_segment_allocator.sv
// First-fit segment allocator.
// req_i (sink): command (0 allocate, 1 free by owner, 2 or 3 report), request_size,
// process_id. rsp_o (source): status, block_start, free_total, allocated_total.
// Each accepted item yields exactly one response item.
// Path from accept to response valid:
//   report or zero-size allocate: straight to the response state.
//   allocate / free: a walk of the table from entry 0 up to the matching segment,
//   or over all segments when nothing matches; a free that hits any segment but
//   the last adds a merge-check state.
//   The walk reads one entry per cycle through a single compare unit.
// One item at a time: req_i.ready is high only while idle, i.e. after the previous
// response has been taken. Splits and merges shift the table together with the
// entry write.
// Reset: table holds one free segment covering all of memory, totals 1024 / 0.
// If the receiver stalls the response is held stable and no new item is taken.
module first_fit_segment_allocator import ffsa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ffsa_req_if.sink   req_i,
  ffsa_rsp_if.source rsp_o
);

  tbl_cmd_t         tbl_cmd;
  logic [IDX_W-1:0] tbl_idx;
  entry_t           tbl_entry;
  logic [CNT_W-1:0] tbl_count;
  logic [LEN_W-1:0] used_total;

  ffsa_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_ready_o  (req_i.ready),
    .req_command_i(req_i.command),
    .req_size_i   (req_i.request_size),
    .req_pid_i    (req_i.process_id),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_status_o (rsp_o.status),
    .rsp_start_o  (rsp_o.block_start),
    .used_total_o (used_total),
    .tbl_cmd_o    (tbl_cmd),
    .tbl_idx_o    (tbl_idx),
    .tbl_entry_i  (tbl_entry),
    .tbl_count_i  (tbl_count)
  );

  ffsa_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (tbl_cmd),
    .rd_idx_i  (tbl_idx),
    .rd_entry_o(tbl_entry),
    .count_o   (tbl_count)
  );

  // segment lengths always add up to the whole memory
  assign rsp_o.allocated_total = used_total;
  assign rsp_o.free_total      = LEN_W'(MEM_SIZE) - used_total;

endmodule

// File: rtl/ffsa_checker.sv
`include "first_fit_segment_allocator_assert.svh"

module ffsa_checker import ffsa_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_ready_i,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input logic [STAT_W-1:0] status_i,
  input logic [BASE_W-1:0] block_start_i,
  input logic [LEN_W-1:0]  free_total_i,
  input logic [LEN_W-1:0]  allocated_total_i
);

  `FFSA_ASSERT_ALWAYS(a_busy_excl, clk_i, rst_ni, !(req_ready_i && rsp_valid_i), "ready while response pending")
  `FFSA_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i, "ready right after accept")
  `FFSA_ASSERT_IMPL(a_totals, clk_i, rst_ni, rsp_valid_i, ({1'b0, free_total_i} + {1'b0, allocated_total_i}) == (LEN_W+1)'(MEM_SIZE), "totals do not cover memory")
  `FFSA_ASSERT_IMPL(a_start_zero, clk_i, rst_ni, rsp_valid_i && (status_i != ST_OK), block_start_i == '0, "start set on failure")
  `FFSA_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(status_i) && $stable(block_start_i), "stalled response changed")

endmodule

bind first_fit_segment_allocator ffsa_checker u_ffsa_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .status_i         (rsp_o.status),
  .block_start_i    (rsp_o.block_start),
  .free_total_i     (rsp_o.free_total),
  .allocated_total_i(rsp_o.allocated_total)
);
